// File: src/gpioev_pkg.sv
// Shared types, register offsets and pin masks of the GPIO event detect controller.
package gpioev_pkg;

   // Pin count and the fixed widths of the two halves of a pin vector.
   localparam int NUM_PINS   = 54;
   localparam int LO_W       = 32;
   localparam int HI_W       = 22;
   localparam int FSEL_WORDS = 6;
   localparam int FSEL_PER   = 10;
   localparam int FSEL_BITS  = 3;
   localparam int FSEL_W     = FSEL_PER * FSEL_BITS;
   localparam int FSEL_PINS  = FSEL_WORDS * FSEL_PER;
   localparam int DIR_PINS   = (NUM_PINS < FSEL_PINS) ? NUM_PINS : FSEL_PINS;
   localparam int PAD_W      = 3;

   // Function select code that makes a pin an output.
   localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'd1;

   // Register word offsets.
   localparam logic [5:0] OFF_FSEL_END = 6'(FSEL_WORDS);
   localparam logic [5:0] OFF_SET_LO   = 6'd7;
   localparam logic [5:0] OFF_SET_HI   = 6'd8;
   localparam logic [5:0] OFF_CLR_LO   = 6'd10;
   localparam logic [5:0] OFF_CLR_HI   = 6'd11;
   localparam logic [5:0] OFF_LEV_LO   = 6'd13;
   localparam logic [5:0] OFF_LEV_HI   = 6'd14;
   localparam logic [5:0] OFF_EVT_LO   = 6'd16;
   localparam logic [5:0] OFF_EVT_HI   = 6'd17;
   localparam logic [5:0] OFF_REN_LO   = 6'd19;
   localparam logic [5:0] OFF_REN_HI   = 6'd20;
   localparam logic [5:0] OFF_FEN_LO   = 6'd22;
   localparam logic [5:0] OFF_FEN_HI   = 6'd23;
   localparam logic [5:0] OFF_HEN_LO   = 6'd25;
   localparam logic [5:0] OFF_HEN_HI   = 6'd26;
   localparam logic [5:0] OFF_LEN_LO   = 6'd28;
   localparam logic [5:0] OFF_LEN_HI   = 6'd29;
   localparam logic [5:0] OFF_PUD      = 6'd37;
   localparam logic [5:0] OFF_PUDCLK_LO = 6'd38;
   localparam logic [5:0] OFF_PUDCLK_HI = 6'd39;

   // Kind of an input beat.
   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // A mask of the n lowest bits of a word.
   function automatic logic [31:0] bits_mask(input int n);
      logic [31:0] m;
      if (n <= 0) begin
         m = '0;
      end else if (n >= 32) begin
         m = '1;
      end else begin
         m = (32'h1 << n) - 32'h1;
      end
      return m;
   endfunction

   // Bits of a function select word that belong to existing pins.
   function automatic logic [FSEL_W-1:0] fsel_mask(input int word);
      int          count;
      logic [31:0] m;
      count = NUM_PINS - FSEL_PER * word;
      if (count > FSEL_PER) begin
         count = FSEL_PER;
      end
      m = bits_mask(FSEL_BITS * count);
      return m[FSEL_W-1:0];
   endfunction

   localparam logic [31:0] PIN_MASK_LO = bits_mask(NUM_PINS);
   localparam logic [31:0] PIN_MASK_HI = bits_mask(NUM_PINS - 32);

   // One accepted input beat.
   typedef struct packed {
      action_type        action;
      logic [5:0]        word_offset;
      logic [31:0]       write_data;
      logic [LO_W-1:0]   pins_low;
      logic [HI_W-1:0]   pins_high;
   } item_type;

   // One result beat.
   typedef struct packed {
      logic [31:0]       read_data;
      logic [LO_W-1:0]   drive_low;
      logic [HI_W-1:0]   drive_high;
      logic [LO_W-1:0]   dir_low;
      logic [HI_W-1:0]   dir_high;
      logic [1:0]        pull_select;
      logic [LO_W-1:0]   pull_strobe_low;
      logic [HI_W-1:0]   pull_strobe_high;
      logic              irq;
   } result_type;

endpackage

// File: src/gpioev_regfile.sv
// Register file of the GPIO controller: bus access, event detection and result forming.
module gpioev_regfile (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  gpioev_pkg::item_type   item,
   output gpioev_pkg::result_type result
);

   logic [gpioev_pkg::FSEL_W-1:0] fsel_ff [gpioev_pkg::FSEL_WORDS];
   logic [gpioev_pkg::FSEL_W-1:0] fsel_in [gpioev_pkg::FSEL_WORDS];
   logic [1:0][31:0] latch_ff, latch_in;
   logic [1:0][31:0] evt_ff, evt_in;
   logic [1:0][31:0] ren_ff, ren_in;
   logic [1:0][31:0] fen_ff, fen_in;
   logic [1:0][31:0] hen_ff, hen_in;
   logic [1:0][31:0] len_ff, len_in;
   logic [1:0][31:0] prev_ff, prev_in;
   logic [1:0][31:0] pudclk_ff, pudclk_in;
   logic [1:0]       pud_ff, pud_in;

   logic [1:0][31:0] pin_mask;
   logic [1:0][31:0] now;
   logic [1:0][31:0] dir;
   logic [31:0]      rd;

   assign pin_mask[0] = gpioev_pkg::PIN_MASK_LO;
   assign pin_mask[1] = gpioev_pkg::PIN_MASK_HI;
   assign now[0] = item.pins_low & gpioev_pkg::PIN_MASK_LO;
   assign now[1] = 32'(item.pins_high) & gpioev_pkg::PIN_MASK_HI;

   // Next state of every register for the beat that leaves the input register.
   always_comb begin
      fsel_in   = fsel_ff;
      latch_in  = latch_ff;
      evt_in    = evt_ff;
      ren_in    = ren_ff;
      fen_in    = fen_ff;
      hen_in    = hen_ff;
      len_in    = len_ff;
      prev_in   = prev_ff;
      pudclk_in = pudclk_ff;
      pud_in    = pud_ff;
      rd        = '0;
      if (advance) begin
         case (item.action)
            gpioev_pkg::ACT_READ: begin
               if (item.word_offset < gpioev_pkg::OFF_FSEL_END) begin
                  rd = 32'(fsel_ff[item.word_offset[2:0]]);
               end else begin
                  case (item.word_offset)
                     gpioev_pkg::OFF_LEV_LO:    rd = prev_ff[0];
                     gpioev_pkg::OFF_LEV_HI:    rd = prev_ff[1];
                     gpioev_pkg::OFF_EVT_LO:    rd = evt_ff[0];
                     gpioev_pkg::OFF_EVT_HI:    rd = evt_ff[1];
                     gpioev_pkg::OFF_REN_LO:    rd = ren_ff[0];
                     gpioev_pkg::OFF_REN_HI:    rd = ren_ff[1];
                     gpioev_pkg::OFF_FEN_LO:    rd = fen_ff[0];
                     gpioev_pkg::OFF_FEN_HI:    rd = fen_ff[1];
                     gpioev_pkg::OFF_HEN_LO:    rd = hen_ff[0];
                     gpioev_pkg::OFF_HEN_HI:    rd = hen_ff[1];
                     gpioev_pkg::OFF_LEN_LO:    rd = len_ff[0];
                     gpioev_pkg::OFF_LEN_HI:    rd = len_ff[1];
                     gpioev_pkg::OFF_PUD:       rd = 32'(pud_ff);
                     gpioev_pkg::OFF_PUDCLK_LO: rd = pudclk_ff[0];
                     gpioev_pkg::OFF_PUDCLK_HI: rd = pudclk_ff[1];
                     default:                   rd = '0;
                  endcase
               end
            end
            gpioev_pkg::ACT_WRITE: begin
               if (item.word_offset < gpioev_pkg::OFF_FSEL_END) begin
                  for (int w = 0; w < gpioev_pkg::FSEL_WORDS; w++) begin
                     if (item.word_offset[2:0] == 3'(w)) begin
                        fsel_in[w] = item.write_data[gpioev_pkg::FSEL_W-1:0] &
                                     gpioev_pkg::fsel_mask(w);
                     end
                  end
               end else begin
                  case (item.word_offset)
                     gpioev_pkg::OFF_SET_LO: latch_in[0] = latch_ff[0] |
                                                           (item.write_data & pin_mask[0]);
                     gpioev_pkg::OFF_SET_HI: latch_in[1] = latch_ff[1] |
                                                           (item.write_data & pin_mask[1]);
                     gpioev_pkg::OFF_CLR_LO: latch_in[0] = latch_ff[0] & ~item.write_data;
                     gpioev_pkg::OFF_CLR_HI: latch_in[1] = latch_ff[1] & ~item.write_data;
                     gpioev_pkg::OFF_EVT_LO: evt_in[0] = evt_ff[0] & ~item.write_data;
                     gpioev_pkg::OFF_EVT_HI: evt_in[1] = evt_ff[1] & ~item.write_data;
                     gpioev_pkg::OFF_REN_LO: ren_in[0] = item.write_data & pin_mask[0];
                     gpioev_pkg::OFF_REN_HI: ren_in[1] = item.write_data & pin_mask[1];
                     gpioev_pkg::OFF_FEN_LO: fen_in[0] = item.write_data & pin_mask[0];
                     gpioev_pkg::OFF_FEN_HI: fen_in[1] = item.write_data & pin_mask[1];
                     gpioev_pkg::OFF_HEN_LO: hen_in[0] = item.write_data & pin_mask[0];
                     gpioev_pkg::OFF_HEN_HI: hen_in[1] = item.write_data & pin_mask[1];
                     gpioev_pkg::OFF_LEN_LO: len_in[0] = item.write_data & pin_mask[0];
                     gpioev_pkg::OFF_LEN_HI: len_in[1] = item.write_data & pin_mask[1];
                     gpioev_pkg::OFF_PUD:    pud_in = item.write_data[1:0];
                     gpioev_pkg::OFF_PUDCLK_LO: pudclk_in[0] = item.write_data & pin_mask[0];
                     gpioev_pkg::OFF_PUDCLK_HI: pudclk_in[1] = item.write_data & pin_mask[1];
                     default: ;
                  endcase
               end
            end
            gpioev_pkg::ACT_TICK: begin
               // Latch every enabled edge or level into the status and keep the sample.
               for (int h = 0; h < 2; h++) begin
                  evt_in[h] = evt_ff[h] | (pin_mask[h] &
                              (( now[h] & ~prev_ff[h] & ren_ff[h]) |
                               (~now[h] &  prev_ff[h] & fen_ff[h]) |
                               ( now[h] & hen_ff[h]) |
                               (~now[h] & len_ff[h])));
                  prev_in[h] = now[h];
               end
            end
            default: ;
         endcase
      end
   end

   // Output enables from the updated function select fields.
   always_comb begin
      dir = '0;
      for (int p = 0; p < gpioev_pkg::DIR_PINS; p++) begin
         dir[p / 32][p % 32] = (fsel_in[p / gpioev_pkg::FSEL_PER]
                                [gpioev_pkg::FSEL_BITS * (p % gpioev_pkg::FSEL_PER) +:
                                 gpioev_pkg::FSEL_BITS] == gpioev_pkg::FSEL_OUTPUT);
      end
   end

   // The result shows the state after the beat.
   always_comb begin
      result.read_data        = rd;
      result.drive_low        = latch_in[0];
      result.drive_high       = latch_in[1][gpioev_pkg::HI_W-1:0];
      result.dir_low          = dir[0];
      result.dir_high         = dir[1][gpioev_pkg::HI_W-1:0];
      result.pull_select      = pud_in;
      result.pull_strobe_low  = pudclk_in[0];
      result.pull_strobe_high = pudclk_in[1][gpioev_pkg::HI_W-1:0];
      result.irq              = |{evt_in[0], evt_in[1]};
   end

   // State registers, all cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < gpioev_pkg::FSEL_WORDS; w++) begin
            fsel_ff[w] <= '0;
         end
         latch_ff  <= '0;
         evt_ff    <= '0;
         ren_ff    <= '0;
         fen_ff    <= '0;
         hen_ff    <= '0;
         len_ff    <= '0;
         prev_ff   <= '0;
         pudclk_ff <= '0;
         pud_ff    <= '0;
      end else begin
         fsel_ff   <= fsel_in;
         latch_ff  <= latch_in;
         evt_ff    <= evt_in;
         ren_ff    <= ren_in;
         fen_ff    <= fen_in;
         hen_ff    <= hen_in;
         len_ff    <= len_in;
         prev_ff   <= prev_in;
         pudclk_ff <= pudclk_in;
         pud_ff    <= pud_in;
      end
   end

`ifndef SYNTHESIS
   // A tick with every detect disabled leaves the event status alone.
   a_tick_no_enable: assert property (@(posedge clock) disable iff (reset)
      advance && item.action == gpioev_pkg::ACT_TICK &&
      ren_ff == '0 && fen_ff == '0 && hen_ff == '0 && len_ff == '0
      |=> $stable(evt_ff))
      else $error("event status changed on a tick with no detect enabled");

   // Writing all ones to the lower status word clears it.
   a_evt_clear: assert property (@(posedge clock) disable iff (reset)
      advance && item.action == gpioev_pkg::ACT_WRITE &&
      item.word_offset == gpioev_pkg::OFF_EVT_LO && item.write_data == '1
      |=> evt_ff[0] == '0)
      else $error("write one to clear left lower event bits set");

   // No stored status or sample bit belongs to a pin that does not exist.
   a_no_ghost_pins: assert property (@(posedge clock) disable iff (reset)
      ((evt_ff[1] | prev_ff[1]) & ~gpioev_pkg::PIN_MASK_HI) == '0)
      else $error("status bit set for a nonexistent pin");
`endif

endmodule

// File: src/gpio_controller_event_detect.sv
// Top level of the GPIO controller with edge and level event detection.
//
// Each request beat is a bus read, a bus write or a pin sample tick, chosen by
// req_tuser; each one gives exactly one response beat that carries the read data
// (zero unless a read) and the pin drive, direction, pull and interrupt state as it
// stands after the beat. One beat is taken every clock cycle while responses are
// accepted; a response is offered once its request has passed the input register
// and then the result register, which bracket the single pass of register update
// logic. A stalled response holds in the result register while the next request
// waits in the input register.
module gpio_controller_event_detect (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // word_offset[5:0], write_data[37:6], pins_low[69:38], pins_high[91:70], zero pad
   input  logic [95:0]  req_tdata,
   // action[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_data[31:0], drive_low[63:32], drive_high[85:64], dir_low[117:86],
   // dir_high[139:118], pull_select[141:140], pull_strobe_low[173:142],
   // pull_strobe_high[195:174], irq[196], zero pad
   output logic [199:0] rsp_tdata
);

   logic                   in_valid_ff;
   gpioev_pkg::item_type   in_item_ff;
   logic                   out_valid_ff;
   gpioev_pkg::result_type out_result_ff;
   gpioev_pkg::item_type   req_item;
   gpioev_pkg::result_type result;
   logic                   advance;
   logic                   req_take;

   // Unpack the request beat.
   always_comb begin
      req_item.action      = gpioev_pkg::action_type'(req_tuser);
      req_item.word_offset = req_tdata[5:0];
      req_item.write_data  = req_tdata[37:6];
      req_item.pins_low    = req_tdata[69:38];
      req_item.pins_high   = req_tdata[91:70];
   end

   // The held beat moves on whenever the result register is free or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   gpioev_regfile u_regfile (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .item   (in_item_ff),
      .result (result)
   );

   // Input register and result register with their valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   // Pack the response beat.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{gpioev_pkg::PAD_W{1'b0}},
                        out_result_ff.irq,
                        out_result_ff.pull_strobe_high,
                        out_result_ff.pull_strobe_low,
                        out_result_ff.pull_select,
                        out_result_ff.dir_high,
                        out_result_ff.dir_low,
                        out_result_ff.drive_high,
                        out_result_ff.drive_low,
                        out_result_ff.read_data};

`ifndef SYNTHESIS
   // A held request that cannot move on stays in place.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("held request lost or changed");

   // A response that is not taken is not overwritten.
   a_hold_output: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !advance)
      else $error("pending response overwritten");

   // Every beat passed on leaves a response behind.
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("response missing after a beat moved on");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the GPIO controller with edge and level event detection.
`timescale 1ns / 100ps

module testbench;

   localparam int STALL_PCT  = 27;
   localparam int HOLD_LEN   = 80;
   localparam int REPORT_MAX = 10;

   // Word offsets with no register behind them, and the bounds of the function select words.
   localparam logic [5:0] OFF_FSEL_FIRST = 6'd0;
   localparam logic [5:0] OFF_FSEL_LAST  = gpioev_pkg::OFF_FSEL_END - 6'd1;
   localparam logic [5:0] OFF_GAP        = 6'd6;
   localparam logic [5:0] OFF_TOP        = 6'd63;

   // Data patterns for the directed beats.
   localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
   localparam logic [31:0] LOW_HALF       = 32'h0000_FFFF;
   localparam logic [31:0] FSEL_ALL_OUT   = 32'h0924_9249;
   localparam logic [31:0] FSEL_TOP_OUT   = 32'h0000_0249;
   localparam logic [1:0]  PULL_RESERVED  = 2'd3;

   // Registers that come in pin pairs, plus the pull mode word.
   localparam logic [5:0] REG_OFFSETS [19] = '{
      gpioev_pkg::OFF_SET_LO, gpioev_pkg::OFF_SET_HI,
      gpioev_pkg::OFF_CLR_LO, gpioev_pkg::OFF_CLR_HI,
      gpioev_pkg::OFF_LEV_LO, gpioev_pkg::OFF_LEV_HI,
      gpioev_pkg::OFF_EVT_LO, gpioev_pkg::OFF_EVT_HI,
      gpioev_pkg::OFF_REN_LO, gpioev_pkg::OFF_REN_HI,
      gpioev_pkg::OFF_FEN_LO, gpioev_pkg::OFF_FEN_HI,
      gpioev_pkg::OFF_HEN_LO, gpioev_pkg::OFF_HEN_HI,
      gpioev_pkg::OFF_LEN_LO, gpioev_pkg::OFF_LEN_HI,
      gpioev_pkg::OFF_PUD, gpioev_pkg::OFF_PUDCLK_LO,
      gpioev_pkg::OFF_PUDCLK_HI
   };

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // word_offset[5:0], write_data[37:6], pins_low[69:38], pins_high[91:70], zero pad
   logic [95:0]  req_tdata  = '0;
   // action[1:0]
   logic [1:0]   req_tuser  = gpioev_pkg::ACT_READ;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // read_data[31:0], drive_low[63:32], drive_high[85:64], dir_low[117:86],
   // dir_high[139:118], pull_select[141:140], pull_strobe_low[173:142],
   // pull_strobe_high[195:174], irq[196], zero pad
   logic [199:0] rsp_tdata;

   gpio_controller_event_detect DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predicted register state of the controller.
   logic [gpioev_pkg::FSEL_W-1:0] fsel_reg [gpioev_pkg::FSEL_WORDS];
   logic [31:0]       latch_reg [2];
   logic [31:0]       event_reg [2];
   logic [31:0]       rise_en [2];
   logic [31:0]       fall_en [2];
   logic [31:0]       high_en [2];
   logic [31:0]       low_en [2];
   logic [31:0]       level_reg [2];
   logic [31:0]       pudclk_reg [2];
   logic [1:0]        pud_reg;

   gpioev_pkg::result_type awaited_status [$];
   gpioev_pkg::result_type due;
   int         failures  = 0;
   int         hold_left = 0;
   bit         steady    = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one accepted beat to the predicted state and returns the response it should give.
   function automatic gpioev_pkg::result_type next_pin_state(input gpioev_pkg::item_type beat);
      gpioev_pkg::result_type        res;
      logic [31:0]                   d;
      logic [31:0]                   keep;
      logic [31:0]                   now;
      logic [31:0]                   ev;
      logic [gpioev_pkg::FSEL_W-1:0] fkeep;
      logic [63:0]                   dir;
      int                            first_pin;
      d   = beat.write_data;
      res = '0;
      case (beat.action)
         gpioev_pkg::ACT_READ: begin
            if (beat.word_offset < gpioev_pkg::OFF_FSEL_END) begin
               res.read_data = 32'(fsel_reg[beat.word_offset[2:0]]);
            end else begin
               case (beat.word_offset)
                  gpioev_pkg::OFF_LEV_LO:    res.read_data = level_reg[0];
                  gpioev_pkg::OFF_LEV_HI:    res.read_data = level_reg[1];
                  gpioev_pkg::OFF_EVT_LO:    res.read_data = event_reg[0];
                  gpioev_pkg::OFF_EVT_HI:    res.read_data = event_reg[1];
                  gpioev_pkg::OFF_REN_LO:    res.read_data = rise_en[0];
                  gpioev_pkg::OFF_REN_HI:    res.read_data = rise_en[1];
                  gpioev_pkg::OFF_FEN_LO:    res.read_data = fall_en[0];
                  gpioev_pkg::OFF_FEN_HI:    res.read_data = fall_en[1];
                  gpioev_pkg::OFF_HEN_LO:    res.read_data = high_en[0];
                  gpioev_pkg::OFF_HEN_HI:    res.read_data = high_en[1];
                  gpioev_pkg::OFF_LEN_LO:    res.read_data = low_en[0];
                  gpioev_pkg::OFF_LEN_HI:    res.read_data = low_en[1];
                  gpioev_pkg::OFF_PUD:       res.read_data = 32'(pud_reg);
                  gpioev_pkg::OFF_PUDCLK_LO: res.read_data = pudclk_reg[0];
                  gpioev_pkg::OFF_PUDCLK_HI: res.read_data = pudclk_reg[1];
                  default:                   res.read_data = '0;
               endcase
            end
         end
         gpioev_pkg::ACT_WRITE: begin
            if (beat.word_offset < gpioev_pkg::OFF_FSEL_END) begin
               // Only the fields of pins that exist are kept.
               fkeep     = '0;
               first_pin = gpioev_pkg::FSEL_PER * int'(beat.word_offset);
               for (int p = 0; p < gpioev_pkg::FSEL_PER; p++) begin
                  if (first_pin + p < gpioev_pkg::NUM_PINS) begin
                     fkeep[gpioev_pkg::FSEL_BITS*p +: gpioev_pkg::FSEL_BITS] = '1;
                  end
               end
               fsel_reg[beat.word_offset[2:0]] = d[gpioev_pkg::FSEL_W-1:0] & fkeep;
            end else begin
               case (beat.word_offset)
                  gpioev_pkg::OFF_SET_LO:
                     latch_reg[0] = latch_reg[0] | (d & gpioev_pkg::PIN_MASK_LO);
                  gpioev_pkg::OFF_SET_HI:
                     latch_reg[1] = latch_reg[1] | (d & gpioev_pkg::PIN_MASK_HI);
                  gpioev_pkg::OFF_CLR_LO:    latch_reg[0] = latch_reg[0] & ~d;
                  gpioev_pkg::OFF_CLR_HI:    latch_reg[1] = latch_reg[1] & ~d;
                  gpioev_pkg::OFF_EVT_LO:    event_reg[0] = event_reg[0] & ~d;
                  gpioev_pkg::OFF_EVT_HI:    event_reg[1] = event_reg[1] & ~d;
                  gpioev_pkg::OFF_REN_LO:    rise_en[0] = d & gpioev_pkg::PIN_MASK_LO;
                  gpioev_pkg::OFF_REN_HI:    rise_en[1] = d & gpioev_pkg::PIN_MASK_HI;
                  gpioev_pkg::OFF_FEN_LO:    fall_en[0] = d & gpioev_pkg::PIN_MASK_LO;
                  gpioev_pkg::OFF_FEN_HI:    fall_en[1] = d & gpioev_pkg::PIN_MASK_HI;
                  gpioev_pkg::OFF_HEN_LO:    high_en[0] = d & gpioev_pkg::PIN_MASK_LO;
                  gpioev_pkg::OFF_HEN_HI:    high_en[1] = d & gpioev_pkg::PIN_MASK_HI;
                  gpioev_pkg::OFF_LEN_LO:    low_en[0] = d & gpioev_pkg::PIN_MASK_LO;
                  gpioev_pkg::OFF_LEN_HI:    low_en[1] = d & gpioev_pkg::PIN_MASK_HI;
                  gpioev_pkg::OFF_PUD:       pud_reg = d[1:0];
                  gpioev_pkg::OFF_PUDCLK_LO: pudclk_reg[0] = d & gpioev_pkg::PIN_MASK_LO;
                  gpioev_pkg::OFF_PUDCLK_HI: pudclk_reg[1] = d & gpioev_pkg::PIN_MASK_HI;
                  default: ;
               endcase
            end
         end
         gpioev_pkg::ACT_TICK: begin
            // Edges compare against the previous sample; levels look at this one alone.
            for (int h = 0; h < 2; h++) begin
               keep = (h == 0) ? gpioev_pkg::PIN_MASK_LO : gpioev_pkg::PIN_MASK_HI;
               now  = ((h == 0) ? beat.pins_low : 32'(beat.pins_high)) & keep;
               ev   = (now & ~level_reg[h] & rise_en[h])
                    | (~now & level_reg[h] & fall_en[h])
                    | (now & high_en[h])
                    | (~now & low_en[h]);
               event_reg[h] = event_reg[h] | (ev & keep);
               level_reg[h] = now;
            end
         end
         default: ;
      endcase

      // A pin drives when its function field selects output.
      dir = '0;
      for (int p = 0; p < gpioev_pkg::DIR_PINS; p++) begin
         if (fsel_reg[p / gpioev_pkg::FSEL_PER]
                     [gpioev_pkg::FSEL_BITS*(p % gpioev_pkg::FSEL_PER) +: gpioev_pkg::FSEL_BITS]
             == gpioev_pkg::FSEL_OUTPUT) begin
            dir[p] = 1'b1;
         end
      end

      res.drive_low        = latch_reg[0];
      res.drive_high       = latch_reg[1][gpioev_pkg::HI_W-1:0];
      res.dir_low          = dir[gpioev_pkg::LO_W-1:0];
      res.dir_high         = dir[gpioev_pkg::LO_W +: gpioev_pkg::HI_W];
      res.pull_select      = pud_reg;
      res.pull_strobe_low  = pudclk_reg[0];
      res.pull_strobe_high = pudclk_reg[1][gpioev_pkg::HI_W-1:0];
      res.irq              = |{event_reg[0], event_reg[1]};
      return res;
   endfunction

   // Offers one beat, with random idle cycles first, and records its prediction on acceptance.
   task automatic send_beat(input gpioev_pkg::action_type act, input logic [5:0] offset,
                            input logic [31:0] data, input logic [31:0] lo,
                            input logic [gpioev_pkg::HI_W-1:0] hi);
      gpioev_pkg::item_type beat;
      beat.action      = act;
      beat.word_offset = offset;
      beat.write_data  = data;
      beat.pins_low    = lo;
      beat.pins_high   = hi;
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0, hi, lo, data, offset};
      do @(posedge clock); while (!req_tready);
      awaited_status.push_back(next_pin_state(beat));
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= REPORT_MAX) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      end
   endtask

   // Function select words, including the top word with only four pins.
   task automatic test_function_select();
      send_beat(gpioev_pkg::ACT_WRITE, OFF_FSEL_FIRST, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, OFF_FSEL_FIRST, FSEL_ALL_OUT, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, OFF_FSEL_LAST, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_READ, OFF_FSEL_LAST, '0, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, OFF_FSEL_LAST, FSEL_TOP_OUT, '0, '0);
      send_beat(gpioev_pkg::ACT_READ, OFF_FSEL_FIRST, '0, '0, '0);
   endtask

   // Set and clear words, with bits of missing pins dropped; set words read back as zero.
   task automatic test_output_latch();
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_SET_LO, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_SET_HI, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_CLR_LO, LOW_HALF, '0, '0);
      send_beat(gpioev_pkg::ACT_READ, gpioev_pkg::OFF_SET_LO, '0, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_CLR_HI, ALL_ONES, '0, '0);
   endtask

   // The first tick after reset sees every pin as previously low, so high pads give rising edges.
   task automatic test_event_detect();
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_REN_LO, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_HEN_HI, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_TICK, OFF_TOP, '0, ALL_ONES, '1);
      send_beat(gpioev_pkg::ACT_READ, gpioev_pkg::OFF_EVT_LO, '0, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_EVT_LO, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_EVT_HI, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_FEN_LO, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_TICK, OFF_FSEL_FIRST, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_READ, gpioev_pkg::OFF_EVT_LO, '0, '0, '0);
   endtask

   // Reserved pull mode, pull clock, the read-only level word, unused offsets and the no-op.
   task automatic test_pull_and_unknown();
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_PUD, 32'(PULL_RESERVED), '0, '0);
      send_beat(gpioev_pkg::ACT_READ, gpioev_pkg::OFF_PUD, '0, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_PUDCLK_HI, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, gpioev_pkg::OFF_LEV_LO, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_WRITE, OFF_TOP, ALL_ONES, '0, '0);
      send_beat(gpioev_pkg::ACT_READ, OFF_TOP, ALL_ONES, ALL_ONES, '1);
      send_beat(gpioev_pkg::ACT_NOP, OFF_GAP, ALL_ONES, ALL_ONES, '1);
   endtask

   // Random mix of reads, writes, ticks and no-ops; both sides run without idling in a window.
   task automatic test_random_traffic(input int count, input int calm_from, input int calm_to);
      gpioev_pkg::action_type          act;
      logic [5:0]                      offset;
      logic [31:0]                     data;
      logic [31:0]                     lo;
      logic [gpioev_pkg::HI_W-1:0]     hi;
      logic [31:0]                     last_lo;
      logic [gpioev_pkg::HI_W-1:0]     last_hi;
      int                              r;
      last_lo = $urandom;
      last_hi = gpioev_pkg::HI_W'($urandom);
      for (int n = 0; n < count; n++) begin
         steady = (n >= calm_from && n < calm_to);
         r = $urandom_range(99);
         if (r < 35) begin
            act = gpioev_pkg::ACT_READ;
         end else if (r < 70) begin
            act = gpioev_pkg::ACT_WRITE;
         end else if (r < 95) begin
            act = gpioev_pkg::ACT_TICK;
         end else begin
            act = gpioev_pkg::ACT_NOP;
         end

         r = $urandom_range(99);
         if (r < 20) begin
            offset = 6'($urandom_range(63));
         end else if (r < 35) begin
            offset = 6'($urandom_range(gpioev_pkg::FSEL_WORDS - 1));
         end else begin
            offset = REG_OFFSETS[5'($urandom_range(18))];
         end

         r = $urandom_range(99);
         if (r < 10) begin
            data = ALL_ONES;
         end else if (r < 15) begin
            data = '0;
         end else if (r < 30) begin
            data = 32'h1 << $urandom_range(31);
         end else begin
            data = $urandom;
         end

         // Pads often move one pin in each half from the last sample so that edges stay sparse.
         r = $urandom_range(99);
         if (r < 5) begin
            lo = ALL_ONES;
            hi = '1;
         end else if (r < 10) begin
            lo = '0;
            hi = '0;
         end else if (r < 55) begin
            lo = last_lo ^ (32'h1 << $urandom_range(31));
            hi = last_hi ^ gpioev_pkg::HI_W'(32'h1 << $urandom_range(gpioev_pkg::HI_W - 1));
         end else begin
            lo = $urandom;
            hi = gpioev_pkg::HI_W'($urandom);
         end
         if (act == gpioev_pkg::ACT_TICK) begin
            last_lo = lo;
            last_hi = hi;
         end

         send_beat(act, offset, data, lo, hi);
      end
      steady = 1'b0;
   endtask

   // The receiver holds off while the sender keeps offering, so the pipeline fills.
   task automatic test_backpressure();
      hold_left = HOLD_LEN;
      test_random_traffic(40, 0, 40);
   endtask

   // The sender stops until every response is back, then carries on.
   task automatic test_drain_pause();
      req_tvalid <= 1'b0;
      while (awaited_status.size() != 0) begin
         @(posedge clock);
      end
      test_random_traffic(80, 0, 0);
   endtask

   // Response ready, with random stalls and an occasional long hold-off.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= STALL_PCT);
      end
   end

   // Each response beat is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_status.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("%0t: response beat with nothing outstanding", $time);
            end
         end else begin
            due = awaited_status.pop_front();
            check_field("read_data", due.read_data, rsp_tdata[31:0]);
            check_field("drive_low", due.drive_low, rsp_tdata[63:32]);
            check_field("drive_high", 32'(due.drive_high), 32'(rsp_tdata[85:64]));
            check_field("dir_low", due.dir_low, rsp_tdata[117:86]);
            check_field("dir_high", 32'(due.dir_high), 32'(rsp_tdata[139:118]));
            check_field("pull_select", 32'(due.pull_select), 32'(rsp_tdata[141:140]));
            check_field("pull_strobe_low", due.pull_strobe_low, rsp_tdata[173:142]);
            check_field("pull_strobe_high", 32'(due.pull_strobe_high),
                        32'(rsp_tdata[195:174]));
            check_field("irq", 32'(due.irq), 32'(rsp_tdata[196]));
         end
      end
   end

   // Run limit.
   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      for (int i = 0; i < gpioev_pkg::FSEL_WORDS; i++) begin
         fsel_reg[i] = '0;
      end
      for (int h = 0; h < 2; h++) begin
         latch_reg[h]  = '0;
         event_reg[h]  = '0;
         rise_en[h]    = '0;
         fall_en[h]    = '0;
         high_en[h]    = '0;
         low_en[h]     = '0;
         level_reg[h]  = '0;
         pudclk_reg[h] = '0;
      end
      pud_reg = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_function_select();
      test_output_latch();
      test_event_detect();
      test_pull_and_unknown();
      test_random_traffic(600, 250, 350);
      test_backpressure();
      test_drain_pause();

      // Let the last responses drain, then wait for anything stray.
      req_tvalid <= 1'b0;
      while (awaited_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
